@@ hdl/i2p_pkg.sv @@
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared constants, character codes and precedence functions for the
// infix to prefix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;
    localparam int PREC_W  = 5;

    typedef logic [CHAR_W-1:0]        char_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [PREC_W-1:0] prec_t;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_CARET  = 8'h5E;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_0      = 8'h30;
    localparam char_t CH_9      = 8'h39;
    localparam char_t CH_UA     = 8'h41;
    localparam char_t CH_UZ     = 8'h5A;
    localparam char_t CH_LA     = 8'h61;
    localparam char_t CH_LZ     = 8'h7A;

    localparam prec_t PIN_ADD   = 5'sd1;
    localparam prec_t PIN_MUL   = 5'sd3;
    localparam prec_t PIN_POW   = 5'sd6;
    localparam prec_t PIN_RPAR  = 5'sd0;
    localparam prec_t PIN_LPAR  = 5'sd9;
    localparam prec_t PIN_OTHER = -5'sd1;
    localparam prec_t PST_ADD   = 5'sd2;
    localparam prec_t PST_MUL   = 5'sd4;
    localparam prec_t PST_POW   = 5'sd5;
    localparam prec_t PST_OTHER = 5'sd0;

    function automatic logic is_alnum(input char_t c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic char_t swap_paren(input char_t c);
        char_t r;
        r = c;
        if (c == CH_LPAREN)
            r = CH_RPAREN;
        else if (c == CH_RPAREN)
            r = CH_LPAREN;
        return r;
    endfunction

    function automatic prec_t prec_in(input char_t c);
        prec_t p;
        unique case (c)
            CH_PLUS, CH_MINUS: p = PIN_ADD;
            CH_STAR, CH_SLASH: p = PIN_MUL;
            CH_CARET:          p = PIN_POW;
            CH_RPAREN:         p = PIN_RPAR;
            CH_LPAREN:         p = PIN_LPAR;
            default:           p = PIN_OTHER;
        endcase
        return p;
    endfunction

    function automatic prec_t prec_stack(input char_t c);
        prec_t p;
        unique case (c)
            CH_PLUS, CH_MINUS: p = PST_ADD;
            CH_STAR, CH_SLASH: p = PST_MUL;
            CH_CARET:          p = PST_POW;
            default:           p = PST_OTHER;
        endcase
        return p;
    endfunction

endpackage

@@ hdl/i2p_ram.sv @@
// ----------------------------------------------------------------------------
// i2p_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/i2p_cmp.sv @@
// ----------------------------------------------------------------------------
// i2p_cmp
// Shared precedence compare unit: decides whether the stack top is popped
// for the character being scanned.
// ----------------------------------------------------------------------------
module i2p_cmp
    import i2p_pkg::*;
(
    input  char_t top_char,
    input  char_t cur_char,
    output logic  pop
);

    always_comb
    begin
        if (cur_char == CH_RPAREN)
            pop = (top_char != CH_LPAREN);
        else
            pop = (prec_stack(top_char) > prec_in(cur_char));
    end

endmodule

@@ hdl/infix_to_prefix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_prefix_converter
// Converts an infix expression, one character per transaction, to prefix.
// ----------------------------------------------------------------------------
// Input channel expr_*: one character per transaction, is_last on the final
// one. Up to 64 characters are stored; later ones are dropped and reported
// through input_truncated. A zero byte ends the expression.
// Output channel prefix_*: one prefix character per transaction, final_char
// on the last. An empty result is one transaction with empty_result set.
// While loading, expr_ready stays high, so characters may come back to back.
// After the last character the sequencer scans the buffer in reverse:
// letters and digits are emitted and '(' pushed from the class state, other
// characters go to the check state, each stack pop adding a wait state, all
// through the one compare unit and the stack RAM port. Ending the scan
// drains the stack, each entry with a wait state. Each result then
// passes RAM read, load and present; prefix_* stays stable while stalled.
// expr_ready is low from the last character until the final result is
// taken; the block then clears its counts and accepts the next expression.
// Reset returns the block to loading with empty buffers, no RAM clearing.
// ----------------------------------------------------------------------------
module infix_to_prefix_converter
    import i2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        expr_valid,
    output logic        expr_ready,
    input  logic [7:0]  expr_char,
    input  logic        is_last,
    output logic        prefix_valid,
    input  logic        prefix_ready,
    output logic [7:0]  prefix_char,
    output logic        final_char,
    output logic        empty_result,
    output logic        input_truncated
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_CLASS,
        S_CHECK,
        S_WAIT,
        S_DRAIN,
        S_DWAIT,
        S_ORD,
        S_OLD,
        S_OHOLD
    } state_t;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    cnt_t   len_reg, len_next;
    logic   zero_reg, zero_next;
    logic   ovf_reg, ovf_next;
    cnt_t   idx_reg, idx_next;
    cnt_t   sp_reg, sp_next;
    cnt_t   oc_reg, oc_next;
    addr_t  optr_reg, optr_next;
    char_t  cur_reg, cur_next;
    char_t  pch_reg, pch_next;
    logic   fin_reg, fin_next;
    logic   emp_reg, emp_next;
    logic   vld_reg, vld_next;

    logic  in_we;
    char_t in_rdata;
    addr_t in_raddr;
    logic  stk_we;
    char_t stk_wdata;
    char_t stk_rdata;
    addr_t stk_raddr;
    logic  emit;
    char_t emit_char;
    logic  out_we;
    char_t out_rdata;
    logic  cmp_pop;
    char_t scan_char;
    cnt_t  idx_m1;
    cnt_t  sp_m1;
    cnt_t  oc_m1;
    logic  in_acc;

    assign idx_m1    = idx_reg - cnt_t'(1);
    assign sp_m1     = sp_reg - cnt_t'(1);
    assign oc_m1     = oc_reg - cnt_t'(1);
    assign in_raddr  = idx_m1[ADDR_W-1:0];
    assign stk_raddr = sp_m1[ADDR_W-1:0];
    assign scan_char = swap_paren(in_rdata);
    assign in_acc    = expr_valid && expr_ready;
    assign in_we     = in_acc && (cnt_reg < cnt_t'(MAX_LEN));
    assign out_we    = emit && (oc_reg < cnt_t'(MAX_LEN));

    i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (expr_char),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (oc_reg[ADDR_W-1:0]),
        .wdata (emit_char),
        .raddr (optr_reg),
        .rdata (out_rdata)
    );

    i2p_cmp u_cmp (
        .top_char (stk_rdata),
        .cur_char (cur_reg),
        .pop      (cmp_pop)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        zero_next  = zero_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        oc_next    = oc_reg;
        optr_next  = optr_reg;
        cur_next   = cur_reg;
        pch_next   = pch_reg;
        fin_next   = fin_reg;
        emp_next   = emp_reg;
        vld_next   = vld_reg;
        stk_we     = 1'b0;
        stk_wdata  = cur_reg;
        emit       = 1'b0;
        emit_char  = stk_rdata;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (in_we)
                    begin
                        cnt_next = cnt_reg + cnt_t'(1);
                        if (!zero_reg)
                        begin
                            if (expr_char == CH_NUL)
                                zero_next = 1'b1;
                            else
                                len_next = cnt_reg + cnt_t'(1);
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        idx_next   = len_next;
                        sp_next    = '0;
                        oc_next    = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (idx_reg == '0)
                    state_next = S_DRAIN;
                else
                    state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cur_next = scan_char;
                if (is_alnum(scan_char))
                begin
                    emit       = 1'b1;
                    emit_char  = scan_char;
                    idx_next   = idx_m1;
                    state_next = S_FETCH;
                end
                else if (scan_char == CH_LPAREN)
                begin
                    stk_wdata = scan_char;
                    if (sp_reg < cnt_t'(MAX_LEN))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + cnt_t'(1);
                    end
                    idx_next   = idx_m1;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((sp_reg != '0) && cmp_pop)
                begin
                    emit       = 1'b1;
                    sp_next    = sp_m1;
                    state_next = S_WAIT;
                end
                else
                begin
                    if (cur_reg == CH_RPAREN)
                    begin
                        // drop the matching open parenthesis
                        if (sp_reg != '0)
                            sp_next = sp_m1;
                    end
                    else if (sp_reg < cnt_t'(MAX_LEN))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + cnt_t'(1);
                    end
                    idx_next   = idx_m1;
                    state_next = S_FETCH;
                end
            end
            S_WAIT:
            begin
                state_next = S_CHECK;
            end
            S_DRAIN:
            begin
                if (sp_reg != '0)
                begin
                    emit       = 1'b1;
                    sp_next    = sp_m1;
                    state_next = S_DWAIT;
                end
                else
                begin
                    optr_next  = oc_m1[ADDR_W-1:0];
                    state_next = S_ORD;
                end
            end
            S_DWAIT:
            begin
                state_next = S_DRAIN;
            end
            S_ORD:
            begin
                if (oc_reg == '0)
                begin
                    pch_next   = CH_NUL;
                    fin_next   = 1'b1;
                    emp_next   = 1'b1;
                    vld_next   = 1'b1;
                    state_next = S_OHOLD;
                end
                else
                begin
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                pch_next   = out_rdata;
                fin_next   = (optr_reg == '0);
                emp_next   = 1'b0;
                vld_next   = 1'b1;
                state_next = S_OHOLD;
            end
            S_OHOLD:
            begin
                if (prefix_ready)
                begin
                    vld_next = 1'b0;
                    if (fin_reg)
                    begin
                        cnt_next   = '0;
                        len_next   = '0;
                        zero_next  = 1'b0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                        oc_next    = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        optr_next  = optr_reg - addr_t'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (out_we)
            oc_next = oc_reg + cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            len_reg   <= '0;
            zero_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            sp_reg    <= '0;
            oc_reg    <= '0;
            optr_reg  <= '0;
            cur_reg   <= '0;
            pch_reg   <= '0;
            vld_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            emp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            zero_reg  <= zero_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            oc_reg    <= oc_next;
            optr_reg  <= optr_next;
            cur_reg   <= cur_next;
            pch_reg   <= pch_next;
            vld_reg   <= vld_next;
            fin_reg   <= fin_next;
            emp_reg   <= emp_next;
        end
    end

    assign expr_ready      = (state_reg == S_LOAD);
    assign prefix_valid    = vld_reg;
    assign prefix_char     = pch_reg;
    assign final_char      = fin_reg;
    assign empty_result    = emp_reg;
    assign input_truncated = ovf_reg;

endmodule

@@ hdl/i2p_checker.sv @@
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks for the infix to prefix converter, bound to the top level.
// ----------------------------------------------------------------------------
module i2p_checker
    import i2p_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        expr_valid,
    input logic        expr_ready,
    input logic        is_last,
    input logic        prefix_valid,
    input logic        prefix_ready,
    input logic [7:0]  prefix_char,
    input logic        final_char,
    input logic        empty_result,
    input logic        input_truncated
);

    // never loading and presenting a result at once
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(expr_ready && prefix_valid))
        else $error("input ready while a result is presented");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (prefix_valid && !prefix_ready) |=>
        (prefix_valid && $stable(prefix_char) && $stable(final_char) &&
         $stable(empty_result) && $stable(input_truncated)))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (prefix_valid && empty_result) |-> (final_char && (prefix_char == CH_NUL)))
        else $error("empty result malformed");

    // accepting the last character takes input ready low
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (expr_valid && expr_ready && is_last) |=> !expr_ready)
        else $error("input ready right after last character");

    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        (prefix_valid && prefix_ready && final_char) |=> (expr_ready && !prefix_valid))
        else $error("no return to loading after final result");

endmodule

bind infix_to_prefix_converter i2p_checker u_i2p_checker (.*);
